// File: rtl/lsbg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsbg_pkg - shared types and constants
// Pixel beat and result beat layouts, CSR indexes and widths for the green
// channel LSB codec.
// ----------------------------------------------------------------------------
package lsbg_pkg;

   localparam int GREEN_W    = 8;
   localparam int BYTE_W     = 8;
   localparam int MSG_LEN_W  = 29;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register index, taken from paddr[2]
   localparam logic CSR_DIRECTION     = 1'b0;
   localparam logic CSR_MESSAGE_BYTES = 1'b1;

   // direction codes
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   typedef struct packed {
      logic [GREEN_W-1:0] green;
      logic [BYTE_W-1:0]  message_byte;
      logic               frame_start;
   } pixel_type;

   typedef struct packed {
      logic [GREEN_W-1:0] green_out;
      logic               take_byte;
      logic [BYTE_W-1:0]  byte_out;
      logic               byte_valid;
      logic               header_done;
   } result_type;

endpackage : lsbg_pkg
`default_nettype wire

// File: rtl/lsbg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsbg_req_if / lsbg_rsp_if - stream channels
// Valid/ready channels for pixel beats into the codec and result beats out.
// ----------------------------------------------------------------------------
interface lsbg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] green;
   logic [7:0] message_byte;
   logic       frame_start;

   modport source (output valid, output green, output message_byte,
                   output frame_start, input ready);
   modport sink   (input valid, input green, input message_byte,
                   input frame_start, output ready);
endinterface : lsbg_req_if

interface lsbg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] green_out;
   logic       take_byte;
   logic [7:0] byte_out;
   logic       byte_valid;
   logic       header_done;

   modport source (output valid, output green_out, output take_byte,
                   output byte_out, output byte_valid, output header_done,
                   input ready);
   modport sink   (input valid, input green_out, input take_byte,
                   input byte_out, input byte_valid, input header_done,
                   output ready);
endinterface : lsbg_rsp_if
`default_nettype wire

// File: rtl/lsbg_pixel_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsbg_pixel_step - per-pixel codec logic
// Works out one pixel's result and the next counter and shift state from the
// current state, the registered pixel beat and the CSRs.
// ----------------------------------------------------------------------------
module lsbg_pixel_step #(
   parameter int HEADER_PIXELS = 64,
   parameter int INDEX_WIDTH   = 32
) (
   input  lsbg_pkg::pixel_type                 pixel,
   input  logic                                direction,
   input  logic [lsbg_pkg::MSG_LEN_W-1:0]      message_bytes,
   input  logic [INDEX_WIDTH-1:0]              pixel_index,
   input  logic [HEADER_PIXELS-1:0]            length_shift,
   input  logic [lsbg_pkg::BYTE_W-1:0]         byte_shift,
   output lsbg_pkg::result_type                result,
   output logic [INDEX_WIDTH-1:0]              pixel_index_next,
   output logic [HEADER_PIXELS-1:0]            length_shift_next,
   output logic [lsbg_pkg::BYTE_W-1:0]         byte_shift_next
);
   import lsbg_pkg::*;

   localparam int HDR_IDX_W = $clog2(HEADER_PIXELS);
   localparam int CMP_W     = (INDEX_WIDTH > HEADER_PIXELS) ? INDEX_WIDTH : HEADER_PIXELS;

   always_comb begin
      logic [INDEX_WIDTH-1:0]   p;
      logic [INDEX_WIDTH-1:0]   m;
      logic [INDEX_WIDTH-1:0]   slot;
      logic [2:0]               pos;
      logic [63:0]              msg_wide;
      logic [HEADER_PIXELS-1:0] len;
      logic [HDR_IDX_W-1:0]     sh;
      logic [HEADER_PIXELS-1:0] prev_len;
      logic [BYTE_W-1:0]        cur;
      logic [BYTE_W-1:0]        prev_byte;
      logic [BYTE_W-1:0]        new_byte;
      logic                     lsb;
      logic                     saturated;
      logic                     in_header;
      logic                     enc_active;
      logic                     dec_active;

      p          = pixel.frame_start ? '0 : pixel_index;
      lsb        = pixel.green[0];
      saturated  = &p;
      in_header  = p < INDEX_WIDTH'(HEADER_PIXELS);
      msg_wide   = 64'(message_bytes);
      len        = msg_wide[HEADER_PIXELS-1:0];
      sh         = HDR_IDX_W'(HEADER_PIXELS - 1) - p[HDR_IDX_W-1:0];
      prev_len   = (p == '0) ? '0 : length_shift;
      m          = p - INDEX_WIDTH'(HEADER_PIXELS);
      slot       = m >> 3;
      pos        = m[2:0];
      enc_active = CMP_W'(slot) < CMP_W'(len);
      dec_active = CMP_W'(slot) < CMP_W'(length_shift);
      cur        = (pos == 3'd0) ? pixel.message_byte : byte_shift;
      prev_byte  = (pos == 3'd0) ? '0 : byte_shift;
      new_byte   = {prev_byte[BYTE_W-2:0], lsb};

      result.green_out   = pixel.green;
      result.take_byte   = 1'b0;
      result.byte_out    = '0;
      result.byte_valid  = 1'b0;
      result.header_done = p >= INDEX_WIDTH'(HEADER_PIXELS - 1);
      length_shift_next  = length_shift;
      byte_shift_next    = byte_shift;

      if (!saturated) begin
         if (in_header) begin
            if (direction == DIR_ENCODE) begin
               result.green_out = {pixel.green[GREEN_W-1:1], len[sh]};
            end else begin
               length_shift_next = {prev_len[HEADER_PIXELS-2:0], lsb};
            end
         end else if (direction == DIR_ENCODE) begin
            if (enc_active) begin
               result.take_byte = (pos == 3'd0);
               result.green_out = {pixel.green[GREEN_W-1:1], cur[BYTE_W-1]};
               byte_shift_next  = {cur[BYTE_W-2:0], 1'b0};
            end
         end else if (dec_active) begin
            byte_shift_next = new_byte;
            if (pos == 3'd7) begin
               result.byte_valid = 1'b1;
               result.byte_out   = new_byte;
            end
         end
      end

      // counter parks at all-ones
      pixel_index_next = saturated ? p : p + INDEX_WIDTH'(1);
   end

endmodule : lsbg_pixel_step
`default_nettype wire

// File: rtl/lsb_green_steganography_codec_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsb_green_steganography_codec_core - LSB codec on the green channel
// Pixel beats enter on req (green, message_byte, frame_start) in raster order;
// one result beat per pixel leaves on rsp. The CSR port sets direction
// (0 embed, 1 extract) at address 0 and message_bytes at address 4.
// In embed mode the first HEADER_PIXELS LSBs carry the length MSB first, then
// each 8-pixel slot carries one byte; take_byte marks the pixel that sampled
// message_byte. In extract mode byte_valid flags each rebuilt byte.
// The pipe is a pixel register, then the codec logic into the result
// register. Throughput is one pixel per cycle while rsp does not stall; the
// pixel counter and shift registers update between the two registers.
// Reset clears the CSRs, the pixel counter and both shift registers and
// empties the pipe. When rsp stalls, the result register holds, the pixel
// register fills behind it and req.ready drops; nothing is lost.
// Configure only while the pipe is empty.
// ----------------------------------------------------------------------------
module lsb_green_steganography_codec_core #(
   parameter int HEADER_PIXELS = 64,
   parameter int INDEX_WIDTH   = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lsbg_req_if.sink                             req,
   lsbg_rsp_if.source                           rsp,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lsbg_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [lsbg_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [lsbg_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import lsbg_pkg::*;

   logic                     direction_ff;
   logic [MSG_LEN_W-1:0]     message_bytes_ff;
   logic                     pix_valid_ff;
   pixel_type                pix_ff;
   pixel_type                pix_in;
   logic                     rsp_valid_ff;
   result_type               rsp_ff;
   result_type               rsp_in;
   logic [INDEX_WIDTH-1:0]   pixel_index_ff;
   logic [INDEX_WIDTH-1:0]   pixel_index_in;
   logic [HEADER_PIXELS-1:0] length_shift_ff;
   logic [HEADER_PIXELS-1:0] length_shift_in;
   logic [BYTE_W-1:0]        byte_shift_ff;
   logic [BYTE_W-1:0]        byte_shift_in;
   logic                     out_free;
   logic                     advance;
   logic                     csr_write;

   // CSR port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[2])
         CSR_DIRECTION:     csr_prdata = CSR_DATA_W'(direction_ff);
         CSR_MESSAGE_BYTES: csr_prdata = CSR_DATA_W'(message_bytes_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff     <= DIR_ENCODE;
         message_bytes_ff <= '0;
      end else if (csr_write) begin
         case (csr_paddr[2])
            CSR_DIRECTION:     direction_ff     <= csr_pwdata[0];
            CSR_MESSAGE_BYTES: message_bytes_ff <= csr_pwdata[MSG_LEN_W-1:0];
            default:           ;
         endcase
      end
   end

   // pipe control
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign advance   = pix_valid_ff && out_free;
   assign req.ready = !pix_valid_ff || advance;

   assign pix_in.green        = req.green;
   assign pix_in.message_byte = req.message_byte;
   assign pix_in.frame_start  = req.frame_start;

   lsbg_pixel_step #(
      .HEADER_PIXELS (HEADER_PIXELS),
      .INDEX_WIDTH   (INDEX_WIDTH)
   ) u_step (
      .pixel             (pix_ff),
      .direction         (direction_ff),
      .message_bytes     (message_bytes_ff),
      .pixel_index       (pixel_index_ff),
      .length_shift      (length_shift_ff),
      .byte_shift        (byte_shift_ff),
      .result            (rsp_in),
      .pixel_index_next  (pixel_index_in),
      .length_shift_next (length_shift_in),
      .byte_shift_next   (byte_shift_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         pixel_index_ff  <= '0;
         length_shift_ff <= '0;
         byte_shift_ff   <= '0;
      end else begin
         if (req.valid && req.ready) begin
            pix_valid_ff <= 1'b1;
         end else if (advance) begin
            pix_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff    <= 1'b1;
            pixel_index_ff  <= pixel_index_in;
            length_shift_ff <= length_shift_in;
            byte_shift_ff   <= byte_shift_in;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         pix_ff <= pix_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.green_out   = rsp_ff.green_out;
   assign rsp.take_byte   = rsp_ff.take_byte;
   assign rsp.byte_out    = rsp_ff.byte_out;
   assign rsp.byte_valid  = rsp_ff.byte_valid;
   assign rsp.header_done = rsp_ff.header_done;

endmodule : lsb_green_steganography_codec_core
`default_nettype wire
